/* src/assert_macros.svh */
// Assertion macros shared by the lexer RTL modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define JL_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the condition holds, the expression must hold in the following cycle.
`define JL_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

/* src/jl_pkg.sv */
// Shared types and constants for the JSON lexer with UTF-8 to Latin-1 mapping.
// No dependencies; the front end, queue, serializer and top module import this package.
package jl_pkg;

  localparam int MAX_NEST_DEFAULT = 63;
  localparam int LEVEL_W          = 6;
  localparam int QDEPTH           = 4;
  localparam int RUN_MAX          = 3;

  typedef enum logic [3:0] {
    TK_STR_OPEN  = 4'd0,
    TK_STR_CHAR  = 4'd1,
    TK_STR_CLOSE = 4'd2,
    TK_OBJ_OPEN  = 4'd3,
    TK_OBJ_CLOSE = 4'd4,
    TK_ARR_OPEN  = 4'd5,
    TK_ARR_CLOSE = 4'd6,
    TK_COLON     = 4'd7,
    TK_COMMA     = 4'd8,
    TK_BARE      = 4'd9
  } kind_t;

  // All results caused by one input byte, queued between front and back.
  typedef struct packed {
    kind_t                   kind;
    logic [1:0]              count;
    logic [RUN_MAX-1:0][7:0] chars;
    logic [LEVEL_W-1:0]      level;
  } run_t;

endpackage

/* src/jl_ifs.sv */
// Valid/ready channel interfaces for the JSON lexer ports.
// Depends on nothing but plain logic; payloads follow the lexer's field widths.
interface jl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface jl_token_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] char_out;
  logic       last_of_run;
  logic [5:0] nest_level;

  modport source(output valid, output token_kind, output char_out, output last_of_run,
                 output nest_level, input ready);
  modport sink(input valid, input token_kind, input char_out, input last_of_run,
               input nest_level, output ready);
endinterface

/* src/jl_front.sv */
// Front end of the lexer: accepts one byte per transfer, tracks string, escape,
// hex and UTF-8 state plus nesting depth, and builds the run of results. Uses jl_pkg.
module jl_front #(
  parameter int MAX_NEST = jl_pkg::MAX_NEST_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  jl_byte_if.sink       byte_in,
  input  logic          queue_full,
  output logic          push,
  output jl_pkg::run_t  push_rec
);
  import jl_pkg::*;

  localparam int DEPTH_CAP = (MAX_NEST < 63) ? MAX_NEST : 63;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  typedef struct packed {
    logic [1:0]              count;
    logic [RUN_MAX-1:0][7:0] chars;
  } map_t;

  // Latin-1 substitution for one code point; chars[0] is delivered first.
  function automatic map_t map_code(input logic [20:0] cp);
    map_t m;
    m.count = 2'd0;
    m.chars = '0;
    case (cp) inside
      [21'h2018:21'h201B]: begin
        m.count = 2'd1; m.chars[0] = CH_APOS;
      end
      [21'h201C:21'h201F]: begin
        m.count = 2'd1; m.chars[0] = CH_QUOTE;
      end
      [21'h2013:21'h2015], 21'h2212: begin
        m.count = 2'd1; m.chars[0] = CH_DASH;
      end
      21'h2026: begin
        m.count = 2'd3; m.chars = {CH_DOT, CH_DOT, CH_DOT};
      end
      21'h2022, 21'h00B7: begin
        m.count = 2'd1; m.chars[0] = CH_STAR;
      end
      21'h2192: begin
        m.count = 2'd2; m.chars[0] = CH_DASH; m.chars[1] = CH_GT;
      end
      21'h2190: begin
        m.count = 2'd2; m.chars[0] = CH_LT; m.chars[1] = CH_DASH;
      end
      21'h00A0, 21'h2009, 21'h200B: begin
        m.count = 2'd1; m.chars[0] = CH_SPACE;
      end
      default: begin
        if (cp >= 21'h20 && cp <= 21'hFF && cp != {13'd0, CH_DEL}) begin
          m.count = 2'd1; m.chars[0] = cp[7:0];
        end
      end
    endcase
    return m;
  endfunction

  // Non-hex characters count as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39)      v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  logic                inside_string, inside_string_next;
  logic                escape_pending, escape_pending_next;
  logic [2:0]          hex_remaining, hex_remaining_next;
  logic [1:0]          utf8_remaining, utf8_remaining_next;
  logic [20:0]         code_accum, code_accum_next;
  logic [LEVEL_W-1:0]  depth_count, depth_count_next;
  logic                accept;
  map_t                mapped;
  logic                use_map;
  logic [20:0]         map_cp;
  run_t                rec;

  assign byte_in.ready = !queue_full;
  assign accept        = byte_in.valid && byte_in.ready;

  always_comb begin
    logic [7:0] c;
    c                   = byte_in.data_byte;
    inside_string_next  = inside_string;
    escape_pending_next = escape_pending;
    hex_remaining_next  = hex_remaining;
    utf8_remaining_next = utf8_remaining;
    code_accum_next     = code_accum;
    depth_count_next    = depth_count;
    use_map             = 1'b0;
    map_cp              = {13'd0, c};
    rec.kind            = TK_STR_CHAR;
    rec.count           = 2'd0;
    rec.chars           = '0;
    rec.chars[0]        = c;

    if (inside_string) begin
      if (utf8_remaining != 2'd0) begin
        if (c[7:6] == 2'b10) begin
          code_accum_next     = {code_accum[14:0], c[5:0]};
          utf8_remaining_next = utf8_remaining - 2'd1;
          if (utf8_remaining == 2'd1) begin
            use_map = 1'b1;
            map_cp  = code_accum_next;
          end
        end else begin
          utf8_remaining_next = 2'd0;
        end
      end else if (hex_remaining != 3'd0) begin
        code_accum_next    = {code_accum[16:0], hex_value(c)};
        hex_remaining_next = hex_remaining - 3'd1;
        if (hex_remaining == 3'd1) begin
          use_map = 1'b1;
          map_cp  = code_accum_next;
        end
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (c == CH_U) begin
          hex_remaining_next = 3'd4;
          code_accum_next    = '0;
        end else if (c == CH_N || c == CH_R || c == CH_T) begin
          use_map = 1'b1;
          map_cp  = {13'd0, CH_SPACE};
        end else if (c != CH_B && c != CH_F) begin
          use_map = 1'b1;
        end
      end else if (c == CH_BSLASH) begin
        escape_pending_next = 1'b1;
      end else if (c == CH_QUOTE) begin
        inside_string_next = 1'b0;
        rec.kind           = TK_STR_CLOSE;
        rec.count          = 2'd1;
      end else if (!c[7]) begin
        use_map = 1'b1;
      end else if (c[7:5] == 3'b110) begin
        code_accum_next     = {16'd0, c[4:0]};
        utf8_remaining_next = 2'd1;
      end else if (c[7:4] == 4'b1110) begin
        code_accum_next     = {17'd0, c[3:0]};
        utf8_remaining_next = 2'd2;
      end else if (c[7:3] == 5'b11110) begin
        code_accum_next     = {18'd0, c[2:0]};
        utf8_remaining_next = 2'd3;
      end
    end else begin
      rec.count = 2'd1;
      if (c == CH_QUOTE) begin
        inside_string_next  = 1'b1;
        escape_pending_next = 1'b0;
        rec.kind            = TK_STR_OPEN;
      end else if (c == CH_LBRACE || c == CH_LBRACK) begin
        if (depth_count < LEVEL_W'(DEPTH_CAP)) depth_count_next = depth_count + 1'b1;
        rec.kind = (c == CH_LBRACE) ? TK_OBJ_OPEN : TK_ARR_OPEN;
      end else if (c == CH_RBRACE || c == CH_RBRACK) begin
        if (depth_count != '0) depth_count_next = depth_count - 1'b1;
        rec.kind = (c == CH_RBRACE) ? TK_OBJ_CLOSE : TK_ARR_CLOSE;
      end else if (c == CH_COLON) begin
        rec.kind = TK_COLON;
      end else if (c == CH_COMMA) begin
        rec.kind = TK_COMMA;
      end else if (c > CH_SPACE) begin
        rec.kind = TK_BARE;
      end else begin
        rec.count = 2'd0;
      end
    end

    mapped = map_code(map_cp);
    if (use_map) begin
      rec.count = mapped.count;
      rec.chars = mapped.chars;
    end
    rec.level = depth_count_next;
  end

  assign push     = accept && (rec.count != 2'd0);
  assign push_rec = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_string  <= 1'b0;
      escape_pending <= 1'b0;
      hex_remaining  <= '0;
      utf8_remaining <= '0;
      code_accum     <= '0;
      depth_count    <= '0;
    end else if (accept) begin
      inside_string  <= inside_string_next;
      escape_pending <= escape_pending_next;
      hex_remaining  <= hex_remaining_next;
      utf8_remaining <= utf8_remaining_next;
      code_accum     <= code_accum_next;
      depth_count    <= depth_count_next;
    end
  end

endmodule

/* src/jl_queue.sv */
// Short queue of result runs between the lexer front end and the output serializer.
// Uses jl_pkg for the run record and queue depth, and assert_macros.svh.
module jl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jl_pkg::run_t  push_rec,
  output logic          full,
  output logic          head_valid,
  output jl_pkg::run_t  head_rec,
  input  logic          pop
);
  import jl_pkg::*;
  `include "assert_macros.svh"

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  run_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  `JL_ASSERT(a_no_push_when_full, !(push && full), "run pushed into a full queue")
  `JL_ASSERT(a_no_pop_when_empty, !(pop && !head_valid), "run popped from an empty queue")
  `JL_ASSERT_NEXT(a_count_grows, push && !pop, count == $past(count) + CW'(1), "count did not grow")

endmodule

/* src/jl_back.sv */
// Output serializer: sends the characters of the head run one transfer at a time.
// Uses jl_pkg for the run record and assert_macros.svh.
module jl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  jl_pkg::run_t  head_rec,
  output logic          pop,
  jl_token_if.source    token_out
);
  import jl_pkg::*;
  `include "assert_macros.svh"

  logic [1:0] idx, idx_next;
  logic       last;
  logic       xfer;

  assign last = (idx == head_rec.count - 2'd1);
  assign xfer = token_out.valid && token_out.ready;
  assign pop  = xfer && last;

  assign token_out.valid       = head_valid;
  assign token_out.token_kind  = head_rec.kind;
  assign token_out.char_out    = head_rec.chars[idx];
  assign token_out.last_of_run = last;
  assign token_out.nest_level  = head_rec.level;

  always_comb begin
    idx_next = idx;
    if (xfer) idx_next = last ? 2'd0 : idx + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) idx <= 2'd0;
    else     idx <= idx_next;
  end

  `JL_ASSERT(a_run_not_empty, !head_valid || head_rec.count != 2'd0, "empty run at queue head")
  `JL_ASSERT(a_idx_in_run, !head_valid || idx < head_rec.count, "character index past run end")
  `JL_ASSERT_NEXT(a_run_stays, xfer && !last, token_out.valid && idx == $past(idx) + 2'd1, "run cut short")

endmodule

/* src/json_lexer_utf8_to_latin1.sv */
// JSON byte lexer with UTF-8 and \u escape decoding to Latin-1. Each accepted byte is
// classified combinationally by the front end, which can take a new byte every cycle
// while the four-entry run queue has room; its run is queued behind earlier runs. The
// output side sends one result per cycle while the receiver is ready, so a byte that
// yields two or three characters (arrows, ellipsis) holds the output for one transfer
// per character; the sustained rate is then one byte per cycle if bytes average at
// most one result each. Bytes that give no result never enter the queue.
// Depends on jl_pkg, jl_ifs.sv, jl_front, jl_queue and jl_back.
module json_lexer_utf8_to_latin1 #(
  parameter int MAX_NEST = jl_pkg::MAX_NEST_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  jl_byte_if.sink     byte_in,
  jl_token_if.source  token_out
);
  import jl_pkg::*;

  logic push;
  run_t push_rec;
  logic full;
  logic head_valid;
  run_t head_rec;
  logic pop;

  jl_front #(.MAX_NEST(MAX_NEST)) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .queue_full (full),
    .push       (push),
    .push_rec   (push_rec)
  );

  jl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (full),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop)
  );

  jl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .token_out  (token_out)
  );

endmodule
